// File: design/xoshiro256ss_integer_draws_assert.svh
// ----------------------------------------------------------------------------
// xoshiro256ss_integer_draws_assert
// assertion macros shared by the generator rtl
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256SS_INTEGER_DRAWS_ASSERT_SVH
`define XOSHIRO256SS_INTEGER_DRAWS_ASSERT_SVH

// same-cycle implication
`define XSI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xsi assertion failed");

// next-cycle implication
`define XSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xsi assertion failed");

`endif

// File: design/xsi_pkg.sv
// ----------------------------------------------------------------------------
// xsi_pkg
// shared types and constants of the xoshiro256** integer generator
// ----------------------------------------------------------------------------
`default_nettype none

package xsi_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_STEPS = WORD_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int unsigned REM_CNT_W = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned IDX_W     = $clog2(NUM_WORDS);
  localparam int unsigned CNT_IN_W  = 7;

  localparam logic [WORD_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_C2     = 64'h94d049bb133111eb;

  localparam int unsigned MIX_SH0   = 30;
  localparam int unsigned MIX_SH1   = 27;
  localparam int unsigned MIX_SH2   = 31;
  localparam int unsigned OUT_ROT   = 7;
  localparam int unsigned STATE_ROT = 45;
  localparam int unsigned STATE_SHL = 17;

  typedef enum logic [1:0] {
    OP_BITS  = 2'd0,
    OP_RANGE = 2'd1,
    OP_SEED  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SD_ADD,
    ST_SD_M1S,
    ST_SD_M1W,
    ST_SD_M2S,
    ST_SD_M2W,
    ST_DECIDE,
    ST_DRAW5,
    ST_DRAW9,
    ST_POST,
    ST_REM_W,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

`default_nettype wire

// File: design/xsi_mul.sv
// ----------------------------------------------------------------------------
// xsi_mul
// digit-serial multiplier, low word of a times b, one 4-bit digit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module xsi_mul import xsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output unit_sts_t         sts_o,
  output logic [WORD_W-1:0] prod_o
);

  logic [WORD_W-1:0]    acc_q, acc_d;
  logic [WORD_W-1:0]    a_sh_q, b_sh_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [WORD_W-1:0]    partial;

  assign partial = WORD_W'(b_sh_q * a_sh_q[DIGIT_W-1:0]);
  assign acc_d   = acc_q + partial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + MUL_CNT_W'(1);
        if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      a_sh_q <= a_i;
      b_sh_q <= b_i;
    end else if (busy_q) begin
      acc_q  <= acc_d;
      a_sh_q <= a_sh_q >> DIGIT_W;
      b_sh_q <= b_sh_q << DIGIT_W;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

`default_nettype wire

// File: design/xsi_rem.sv
// ----------------------------------------------------------------------------
// xsi_rem
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module xsi_rem import xsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output unit_sts_t         sts_o,
  output logic [WORD_W-1:0] rem_o
);

  logic [WORD_W-1:0]    rem_q, dvd_q, dsr_q;
  logic [REM_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [WORD_W:0]      trial, diff;

  assign trial = {rem_q, dvd_q[WORD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + REM_CNT_W'(1);
        if (cnt_q == REM_CNT_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (diff[WORD_W]) begin
        rem_q <= trial[WORD_W-1:0];
      end else begin
        rem_q <= diff[WORD_W-1:0];
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

`default_nettype wire

// File: design/xoshiro256ss_integer_draws.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_integer_draws
// xoshiro256** integer generator with splitmix64 seeding
// ----------------------------------------------------------------------------
// input beats carry op, bit_count, low_bound, high_bound and seed_value; each
// input beat gives exactly one output beat carrying value. the block works on
// one beat at a time: in_stall_o is low only while it is idle.
// from input to output beat:
//   reseed: four splitmix64 steps, each with two digit-serial multiplies
//   low-bit draw: one xoshiro256** step; range draw: that step, then the
//     bit-serial remainder; unused op: straight to the output stage
//   the first draw after reset adds the seeding from default_seed
// default_seed is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while idle; the block does not enforce it. reset clears the seeded flag,
// default_seed and the output valid flag. a finished result sits in the output
// register while out_stall_i is high; the next input beat is taken meanwhile
// and its result waits until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro256ss_integer_draws import xsi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [WORD_W-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                op_i,
  input  logic [CNT_IN_W-1:0]       bit_count_i,
  input  logic signed [WORD_W-1:0]  low_bound_i,
  input  logic signed [WORD_W-1:0]  high_bound_i,
  input  logic signed [WORD_W-1:0]  seed_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [WORD_W-1:0]  value_o
);

  state_e              state_q, state_d;
  logic [WORD_W-1:0]   default_seed_q;
  logic                seeded_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    idx_q;

  op_e                 op_q;
  logic [CNT_IN_W-1:0] n_q;
  logic [WORD_W-1:0]   lo_q, hi_q, span_q, acc_q, t_q, draw_q, res_q, out_value_q;
  logic [WORD_W-1:0]   gen_q [NUM_WORDS];

  logic                in_beat, out_free, range_empty;
  logic                mul_start, rem_start;
  logic [WORD_W-1:0]   mul_a, mul_b, mul_p, rem_value;
  unit_sts_t           mul_sts, rem_sts;
  logic [WORD_W-1:0]   t2, t3, rot_t, draw_mask, mixed;

  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign range_empty = $signed(hi_q) < $signed(lo_q);

  assign mul_a = (state_q == ST_SD_M1S) ? (acc_q ^ (acc_q >> MIX_SH0))
                                        : (mul_p ^ (mul_p >> MIX_SH1));
  assign mul_b = (state_q == ST_SD_M1S) ? MIX_C1 : MIX_C2;
  assign mixed = mul_p ^ (mul_p >> MIX_SH2);

  assign t2        = gen_q[2] ^ gen_q[0];
  assign t3        = gen_q[3] ^ gen_q[1];
  assign rot_t     = (t_q << OUT_ROT) | (t_q >> (WORD_W - OUT_ROT));
  assign draw_mask = ~({WORD_W{1'b1}} << n_q[CNT_IN_W-2:0]);

  xsi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .prod_o  (mul_p)
  );

  xsi_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (draw_q),
    .divisor_i  (span_q),
    .sts_o      (rem_sts),
    .rem_o      (rem_value)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_SEED:            state_d = ST_SD_ADD;
            OP_BITS, OP_RANGE:  state_d = seeded_q ? ST_DECIDE : ST_SD_ADD;
            default:            state_d = ST_FIN;
          endcase
        end
      end
      ST_SD_ADD: state_d = ST_SD_M1S;
      ST_SD_M1S: state_d = ST_SD_M1W;
      ST_SD_M1W: begin
        if (mul_sts.done) state_d = ST_SD_M2S;
      end
      ST_SD_M2S: state_d = ST_SD_M2W;
      ST_SD_M2W: begin
        if (mul_sts.done) begin
          if (idx_q != IDX_W'(NUM_WORDS - 1)) begin
            state_d = ST_SD_ADD;
          end else if (op_q == OP_SEED) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (op_q == OP_BITS) begin
          state_d = (n_q == '0) ? ST_FIN : ST_DRAW5;
        end else begin
          state_d = range_empty ? ST_FIN : ST_DRAW5;
        end
      end
      ST_DRAW5: state_d = ST_DRAW9;
      ST_DRAW9: state_d = ST_POST;
      ST_POST: begin
        state_d = (op_q == OP_RANGE && span_q != '0) ? ST_REM_W : ST_FIN;
      end
      ST_REM_W: begin
        if (rem_sts.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o = 1'b1;
    mul_start  = 1'b0;
    rem_start  = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SD_M1S: mul_start = 1'b1;
      ST_SD_M2S: mul_start = 1'b1;
      ST_POST:   rem_start = (op_q == OP_RANGE) && (span_q != '0);
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      default_seed_q <= '0;
      seeded_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      idx_q          <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        default_seed_q <= cfg_wdata_i;
      end
      if (in_beat) begin
        idx_q <= '0;
      end else if (state_q == ST_SD_M2W && mul_sts.done) begin
        idx_q <= idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(NUM_WORDS - 1)) begin
          seeded_q <= 1'b1;
        end
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q  <= op_e'(op_i);
          n_q   <= bit_count_i;
          lo_q  <= low_bound_i;
          hi_q  <= high_bound_i;
          res_q <= '0;
          acc_q <= (op_e'(op_i) == OP_SEED) ? seed_value_i : default_seed_q;
        end
      end
      ST_SD_ADD: acc_q <= acc_q + MIX_GOLDEN;
      ST_SD_M2W: begin
        if (mul_sts.done) gen_q[idx_q] <= mixed;
      end
      ST_DECIDE: begin
        span_q <= hi_q - lo_q + WORD_W'(1);
        if (op_q == OP_RANGE && range_empty) res_q <= lo_q;
      end
      ST_DRAW5: begin
        t_q      <= gen_q[1] + (gen_q[1] << 2);
        gen_q[0] <= gen_q[0] ^ t3;
        gen_q[1] <= gen_q[1] ^ t2;
        gen_q[2] <= t2 ^ (gen_q[1] << STATE_SHL);
        gen_q[3] <= (t3 << STATE_ROT) | (t3 >> (WORD_W - STATE_ROT));
      end
      ST_DRAW9: draw_q <= rot_t + (rot_t << 3);
      ST_POST: begin
        if (op_q == OP_BITS) begin
          res_q <= n_q[CNT_IN_W-1] ? draw_q : (draw_q & draw_mask);
        end else if (span_q == '0) begin
          res_q <= lo_q + draw_q;
        end
      end
      ST_REM_W: begin
        if (rem_sts.done) res_q <= lo_q + rem_value;
      end
      ST_FIN: begin
        if (out_free) out_value_q <= res_q;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

`include "xoshiro256ss_integer_draws_assert.svh"

  `XSI_ASSERT_IMPL(a_units_exclusive, mul_sts.busy, !rem_sts.busy)
  `XSI_ASSERT_IMPL(a_mul_done_wait, mul_sts.done, (state_q == ST_SD_M1W || state_q == ST_SD_M2W))
  `XSI_ASSERT_NEXT(a_seeded_sticky, seeded_q, seeded_q)
  `XSI_ASSERT_IMPL(a_rem_below_span, rem_sts.done, rem_value < span_q)

endmodule

`default_nettype wire
